// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle and |=> implication checks, disabled during reset
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/sbsmv_pkg.sv =====
`default_nettype none

package sbsmv_pkg;

   localparam int LANES    = 4;
   localparam int LANE_W   = $clog2(LANES);
   localparam int VALUE_W  = 32;
   localparam int COLUMN_W = 12;
   localparam int ROW_W    = 12;
   localparam int SUM_W    = 64;
   localparam int POS_W    = 13;

   localparam int DEFAULT_VECTOR_DEPTH = 4096;
   localparam int DEFAULT_ROW_DEPTH    = 4096;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_CROSSROW_ROWS = 3'd0;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic [1:0] {
      KIND_VECTOR = 2'd0,
      KIND_ROWMAP = 2'd1,
      KIND_CHUNK  = 2'd2,
      KIND_BEGIN  = 2'd3
   } kind_type;

   typedef struct packed {
      logic write;
      logic start;
      logic clear;
   } lane_ctrl_type;

   typedef struct packed {
      logic map_write;
      logic start;
      logic inrow;
      logic restart;
   } merge_ctrl_type;

   typedef logic [LANES-1:0][SUM_W-1:0] sum_vec_type;

   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] a,
      input logic signed [SUM_W-1:0] b
   );
      logic signed [SUM_W:0] s;
      s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
      if (s[SUM_W] != s[SUM_W-1]) begin
         return s[SUM_W] ? SUM_MIN : SUM_MAX;
      end
      return s[SUM_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/sbsmv_lane.sv =====
`default_nettype none

module sbsmv_lane #(
   parameter int VECTOR_DEPTH = sbsmv_pkg::DEFAULT_VECTOR_DEPTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire sbsmv_pkg::lane_ctrl_type              ctrl,
   input  wire logic        [sbsmv_pkg::COLUMN_W-1:0] wr_addr,
   input  wire logic signed [sbsmv_pkg::VALUE_W-1:0]  wr_data,
   input  wire logic signed [sbsmv_pkg::VALUE_W-1:0]  value,
   input  wire logic        [sbsmv_pkg::COLUMN_W-1:0] column,
   output logic signed      [sbsmv_pkg::SUM_W-1:0]    lane_sum,
   output logic                                       done
);
   import sbsmv_pkg::*;

   localparam int VAW = $clog2(VECTOR_DEPTH);
   localparam int XW  = (VAW > COLUMN_W) ? VAW : COLUMN_W;

   logic signed [VALUE_W-1:0] vec_mem [VECTOR_DEPTH];

   logic [XW-1:0]  raddr_ext;
   logic [XW-1:0]  waddr_ext;
   logic [VAW-1:0] raddr;
   logic [VAW-1:0] waddr;

   logic signed [VALUE_W-1:0] x_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [SUM_W-1:0]   prod_ff;
   logic signed [SUM_W-1:0]   prod_in;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SUM_W-1:0]   sum_in;
   logic                      s1_ff;
   logic                      s2_ff;
   logic                      done_ff;

   // column wraps modulo the store depth
   assign raddr_ext = XW'(column);
   assign waddr_ext = XW'(wr_addr);
   assign raddr     = raddr_ext[VAW-1:0];
   assign waddr     = waddr_ext[VAW-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.write) begin
         vec_mem[waddr] <= wr_data;
      end
      if (ctrl.start) begin
         x_ff     <= vec_mem[raddr];
         value_ff <= value;
      end
      prod_ff <= prod_in;
   end

   assign prod_in = value_ff * x_ff;

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.clear) begin
         sum_in = '0;
      end else if (s2_ff) begin
         sum_in = sat_add(sum_ff, prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= 1'b0;
         s2_ff   <= 1'b0;
         done_ff <= 1'b0;
         sum_ff  <= '0;
      end else begin
         s1_ff   <= ctrl.start;
         s2_ff   <= s1_ff;
         done_ff <= s2_ff;
         sum_ff  <= sum_in;
      end
   end

   assign lane_sum = sum_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// ===== src/sbsmv_merge.sv =====
`default_nettype none

module sbsmv_merge #(
   parameter int ROW_DEPTH = sbsmv_pkg::DEFAULT_ROW_DEPTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire sbsmv_pkg::merge_ctrl_type             ctrl,
   input  wire logic        [sbsmv_pkg::COLUMN_W-1:0] map_addr,
   input  wire logic        [sbsmv_pkg::ROW_W-1:0]    map_data,
   input  wire logic        [sbsmv_pkg::POS_W-1:0]    crossrow_rows,
   input  wire sbsmv_pkg::sum_vec_type                lane_sums,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_valid,
   output logic             [sbsmv_pkg::ROW_W-1:0]    rsp_row_index,
   output logic signed      [sbsmv_pkg::SUM_W-1:0]    rsp_row_sum,
   output logic                                       rsp_last_of_run,
   output logic                                       done
);
   import sbsmv_pkg::*;

   localparam int RAW = $clog2(ROW_DEPTH);
   localparam int PW  = POS_W + 1;
   localparam int MXW = (RAW > PW) ? RAW : PW;

   typedef enum logic [3:0] {
      M_IDLE = 4'b0001,
      M_SCAN = 4'b0010,
      M_SUM  = 4'b0100,
      M_EMIT = 4'b1000
   } merge_state_type;

   logic [ROW_W-1:0] map_mem [ROW_DEPTH];

   merge_state_type state_ff, state_in;
   logic [LANE_W-1:0]        idx_ff, idx_in;
   logic signed [SUM_W-1:0]  total_ff, total_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic                     last_ff, last_in;
   logic                     inrow_ff, inrow_in;
   logic [POS_W-1:0]         cross_pos_ff, cross_pos_in;
   logic [POS_W-1:0]         inrow_pos_ff, inrow_pos_in;
   logic [ROW_W-1:0]         map_rd_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]         rsp_row_ff, rsp_row_in;
   logic signed [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     load_ok;
   logic signed [SUM_W-1:0]  sel_sum;
   logic signed [SUM_W-1:0]  total_next;
   logic [PW-1:0]            cross_pos_wide;
   logic [PW-1:0]            inrow_pos_wide;
   logic [PW-1:0]            rows_wide;
   logic                     qualify;
   logic                     cross_last;
   logic                     rd_en;
   logic [PW-1:0]            rd_pos;
   logic [MXW-1:0]           rd_pos_ext;
   logic [MXW-1:0]           wr_pos_ext;
   logic [RAW-1:0]           rd_addr;
   logic [RAW-1:0]           wr_addr;
   logic                     done_in;

   assign rows_wide      = PW'(crossrow_rows);
   assign cross_pos_wide = PW'(cross_pos_ff) + PW'(idx_ff);
   assign inrow_pos_wide = rows_wide + PW'(inrow_pos_ff);
   assign qualify        = cross_pos_wide < rows_wide;
   assign cross_last     = (idx_ff == LANE_W'(LANES - 1)) ||
                           ((cross_pos_wide + PW'(1)) >= rows_wide);
   assign sel_sum        = $signed(lane_sums[idx_ff]);
   assign total_next     = sat_add(total_ff, sel_sum);
   assign load_ok        = !rsp_valid_ff || !rsp_stall;

   // sorted positions wrap modulo the map depth
   assign rd_pos_ext = MXW'(rd_pos);
   assign wr_pos_ext = MXW'(map_addr);
   assign rd_addr    = rd_pos_ext[RAW-1:0];
   assign wr_addr    = wr_pos_ext[RAW-1:0];

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      total_in     = total_ff;
      sum_in       = sum_ff;
      last_in      = last_ff;
      inrow_in     = inrow_ff;
      cross_pos_in = cross_pos_ff;
      inrow_pos_in = inrow_pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_row_in   = rsp_row_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_last_in  = rsp_last_ff;
      rd_en        = 1'b0;
      rd_pos       = cross_pos_wide;
      done_in      = 1'b0;

      case (state_ff)
         M_IDLE: begin
            if (ctrl.restart) begin
               cross_pos_in = '0;
               inrow_pos_in = '0;
            end
            if (ctrl.start) begin
               idx_in   = '0;
               total_in = '0;
               inrow_in = ctrl.inrow;
               state_in = ctrl.inrow ? M_SUM : M_SCAN;
            end
         end
         M_SCAN: begin
            if (qualify) begin
               rd_en    = 1'b1;
               sum_in   = sel_sum;
               last_in  = cross_last;
               state_in = M_EMIT;
            end else begin
               cross_pos_in = cross_pos_ff + POS_W'(LANES);
               done_in      = 1'b1;
               state_in     = M_IDLE;
            end
         end
         M_SUM: begin
            total_in = total_next;
            if (idx_ff == LANE_W'(LANES - 1)) begin
               rd_en    = 1'b1;
               rd_pos   = inrow_pos_wide;
               sum_in   = total_next;
               last_in  = 1'b1;
               state_in = M_EMIT;
            end else begin
               idx_in = idx_ff + LANE_W'(1);
            end
         end
         M_EMIT: begin
            if (load_ok) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = map_rd_ff;
               rsp_sum_in   = sum_ff;
               rsp_last_in  = last_ff;
               if (last_ff) begin
                  done_in  = 1'b1;
                  state_in = M_IDLE;
                  if (inrow_ff) begin
                     inrow_pos_in = inrow_pos_ff + POS_W'(1);
                  end else begin
                     cross_pos_in = cross_pos_ff + POS_W'(LANES);
                  end
               end else begin
                  idx_in   = idx_ff + LANE_W'(1);
                  state_in = M_SCAN;
               end
            end
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.map_write) begin
         map_mem[wr_addr] <= map_data;
      end
      if (rd_en) begin
         map_rd_ff <= map_mem[rd_addr];
      end
      idx_ff      <= idx_in;
      total_ff    <= total_in;
      sum_ff      <= sum_in;
      last_ff     <= last_in;
      inrow_ff    <= inrow_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= M_IDLE;
         cross_pos_ff <= '0;
         inrow_pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cross_pos_ff <= cross_pos_in;
         inrow_pos_ff <= inrow_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_index   = rsp_row_ff;
   assign rsp_row_sum     = rsp_sum_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign done            = done_in;

endmodule

`default_nettype wire

// ===== src/sliced_block_sparse_matvec.sv =====
// channel  direction  transfer when            payload
// req      in         req_valid & !req_stall   kind, lane values, lane columns, block flags
// rsp      out        rsp_valid & !rsp_stall   row_index, row_sum, last_of_run
// csr      in         psel & penable & pwrite  crossrow_rows at byte address 0
//
// vector and row map loads and begin leave the block idle
// a chunk steps through lane read, multiply, accumulate and the return to idle
// a closing cross-row chunk adds a scan and an emit step per result, or only a scan when no row comes out
// a closing in-row chunk adds a 4-step lane reduction and an emit step
// synchronous reset clears lane sums and positions; the stores are not cleared
// a stalled result holds the merge, which holds the input side
`default_nettype none

`include "assert_macros.svh"

module sliced_block_sparse_matvec #(
   parameter int VECTOR_DEPTH = sbsmv_pkg::DEFAULT_VECTOR_DEPTH,
   parameter int ROW_DEPTH    = sbsmv_pkg::DEFAULT_ROW_DEPTH
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,

   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic        [1:0]                       req_kind,
   input  wire logic signed [sbsmv_pkg::VALUE_W-1:0]    req_lane_value_0,
   input  wire logic signed [sbsmv_pkg::VALUE_W-1:0]    req_lane_value_1,
   input  wire logic signed [sbsmv_pkg::VALUE_W-1:0]    req_lane_value_2,
   input  wire logic signed [sbsmv_pkg::VALUE_W-1:0]    req_lane_value_3,
   input  wire logic        [sbsmv_pkg::COLUMN_W-1:0]   req_lane_column_0,
   input  wire logic        [sbsmv_pkg::COLUMN_W-1:0]   req_lane_column_1,
   input  wire logic        [sbsmv_pkg::COLUMN_W-1:0]   req_lane_column_2,
   input  wire logic        [sbsmv_pkg::COLUMN_W-1:0]   req_lane_column_3,
   input  wire logic                                    req_end_of_block,
   input  wire logic                                    req_in_row_block,

   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic             [sbsmv_pkg::ROW_W-1:0]      rsp_row_index,
   output logic signed      [sbsmv_pkg::SUM_W-1:0]      rsp_row_sum,
   output logic                                         rsp_last_of_run,

   input  wire logic                                    csr_psel,
   input  wire logic                                    csr_penable,
   input  wire logic                                    csr_pwrite,
   input  wire logic        [sbsmv_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic        [sbsmv_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic             [sbsmv_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                         csr_pready
);
   import sbsmv_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_LANES = 3'b010,
      ST_MERGE = 3'b100
   } top_state_type;

   top_state_type state_ff, state_in;
   logic                 eob_ff, eob_in;
   logic                 inrow_ff, inrow_in;
   logic [POS_W-1:0]     rows_ff, rows_in;

   logic                 req_accept;
   logic                 csr_write;
   logic [LANES-1:0]     lane_done;
   logic                 lanes_done;
   logic                 merge_done;
   lane_ctrl_type        lane_ctrl;
   merge_ctrl_type       merge_ctrl;
   sum_vec_type          lane_sums;

   logic signed [VALUE_W-1:0]  lane_value  [LANES];
   logic        [COLUMN_W-1:0] lane_column [LANES];

   assign lane_value[0]  = req_lane_value_0;
   assign lane_value[1]  = req_lane_value_1;
   assign lane_value[2]  = req_lane_value_2;
   assign lane_value[3]  = req_lane_value_3;
   assign lane_column[0] = req_lane_column_0;
   assign lane_column[1] = req_lane_column_1;
   assign lane_column[2] = req_lane_column_2;
   assign lane_column[3] = req_lane_column_3;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign lanes_done = &lane_done;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rows_in    = (csr_write && (csr_paddr == CSR_ADDR_CROSSROW_ROWS)) ?
                       csr_pwdata[POS_W-1:0] : rows_ff;
   assign csr_prdata = (csr_paddr == CSR_ADDR_CROSSROW_ROWS) ? CSR_DATA_W'(rows_ff) : '0;

   assign lane_ctrl.write = req_accept && (req_kind == KIND_VECTOR);
   assign lane_ctrl.start = req_accept && (req_kind == KIND_CHUNK);
   assign lane_ctrl.clear = (req_accept && (req_kind == KIND_BEGIN)) || merge_done;

   assign merge_ctrl.map_write = req_accept && (req_kind == KIND_ROWMAP);
   assign merge_ctrl.start     = (state_ff == ST_LANES) && lanes_done && eob_ff;
   assign merge_ctrl.inrow     = inrow_ff;
   assign merge_ctrl.restart   = req_accept && (req_kind == KIND_BEGIN);

   always_comb begin
      state_in = state_ff;
      eob_in   = eob_ff;
      inrow_in = inrow_ff;
      case (state_ff)
         ST_IDLE: begin
            if (lane_ctrl.start) begin
               eob_in   = req_end_of_block;
               inrow_in = req_in_row_block;
               state_in = ST_LANES;
            end
         end
         ST_LANES: begin
            if (lanes_done) begin
               state_in = eob_ff ? ST_MERGE : ST_IDLE;
            end
         end
         ST_MERGE: begin
            if (merge_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      eob_ff   <= eob_in;
      inrow_ff <= inrow_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      sbsmv_lane #(
         .VECTOR_DEPTH (VECTOR_DEPTH)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (lane_ctrl),
         .wr_addr  (req_lane_column_0),
         .wr_data  (req_lane_value_0),
         .value    (lane_value[g]),
         .column   (lane_column[g]),
         .lane_sum (lane_sums[g]),
         .done     (lane_done[g])
      );
   end

   sbsmv_merge #(
      .ROW_DEPTH (ROW_DEPTH)
   ) u_merge (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (merge_ctrl),
      .map_addr        (req_lane_column_0),
      .map_data        (req_lane_value_0[ROW_W-1:0]),
      .crossrow_rows   (rows_ff),
      .lane_sums       (lane_sums),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_row_index   (rsp_row_index),
      .rsp_row_sum     (rsp_row_sum),
      .rsp_last_of_run (rsp_last_of_run),
      .done            (merge_done)
   );

   `ASSERT_IMPLY(a_lanes_done_in_lanes, clock, reset, lanes_done, state_ff == ST_LANES)
   `ASSERT_IMPLY(a_merge_done_in_merge, clock, reset, merge_done, state_ff == ST_MERGE)
   `ASSERT_NEXT(a_chunk_holds_input, clock, reset, lane_ctrl.start, req_stall)
   `ASSERT_IMPLY(a_no_load_while_busy, clock, reset, state_ff != ST_IDLE, !lane_ctrl.write && !merge_ctrl.map_write)

endmodule

`default_nettype wire
